// ===== sv/pidc_pkg.sv =====
package pidc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_RECIP,
        ST_MUL_HUND,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KI_GAIN      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KD_GAIN      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_CAP = 8'd3;

    localparam int MUL_W = 32;

    // Truncating divide by 100: q0 = (m * floor(2^37 / 100)) >> 37 is exact or
    // one short for any magnitude below 2^31.
    localparam int                DIV_SCALE   = 100;
    localparam int                RECIP_SHIFT = 37;
    localparam logic [MUL_W-1:0]  RECIP       = 32'd1374389534;
    localparam int                QUOT_W      = 2 * MUL_W - RECIP_SHIFT;

    localparam logic signed [15:0] CORR_SAT     = 16'sd100;
    localparam logic signed [23:0] DRIVE_STEP   = 24'sd120;
    localparam logic signed [14:0] DRIVE_LIMIT  = 15'sd12000;

endpackage

// ===== sv/pid_controller_step.sv =====
// Discrete PID controller step for one control channel.
//
// Input channel (s_*): one transaction per control tick carries a setpoint and
// a measured value. The error is setpoint minus measured; the integral input is
// the wrapped sum of the three errors held before the tick, and the derivative
// input is the new error minus the previous one.
// Result channel (m_*): one transaction per tick carries the 16-bit correction
// (P + I + D, each gain*value/100 truncated toward zero, I clamped to +-cap if
// nonzero) and the drive in millivolts, -120 * correction saturated to +-12000.
// Configuration channel (cfg_*): writes kp, ki, kd and the integral cap. It is
// always ready; writes to unknown indexes are ignored.
//
// The three terms go one after another through a single 32x32 multiplier,
// each through the steps gain product, reciprocal product, back-multiply by
// 100 and correction step. A new tick is taken only once the result is done.
// The block is not ready while a tick is being worked on.
//
// Reset (aresetn low, synchronous) clears the gains, the cap, the error history
// and the result valid. A stalled receiver holds the result in the output
// register; the block still takes and computes the next tick, and then waits
// with that result until the held one has been taken.
module pid_controller_step (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] correction, [30:16] drive_mv, [31] zero

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);

    pidc_pkg::state_t state_reg, state_next;
    pidc_pkg::term_t  term_reg;

    logic signed [15:0] kp_reg, ki_reg, kd_reg;
    logic [6:0]         cap_reg;

    logic signed [15:0] e0_reg, e1_reg, e2_reg;
    logic signed [15:0] window_reg, diff_reg;
    logic signed [15:0] acc_reg;
    logic               neg_reg;
    logic [30:0]        mag_reg;
    logic [pidc_pkg::QUOT_W-1:0] q_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic [pidc_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [2*pidc_pkg::MUL_W-1:0] mul_p;

    logic signed [15:0] cur_value, cur_gain;
    logic [16:0]        value_abs, gain_abs;
    logic               s_accept, out_free;

    logic signed [15:0] sp_in, ms_in, err_in;
    logic [31:0]        rem;
    logic [pidc_pkg::QUOT_W-1:0] q_fixed;
    logic signed [15:0] term_raw, term_val, cap_s;

    logic signed [23:0] drive_prod;
    logic signed [14:0] drive_val;

    pidc_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign sp_in  = s_tdata[15:0];
    assign ms_in  = s_tdata[31:16];
    assign err_in = sp_in - ms_in;

    // Operands of the term now in the multiplier.
    always_comb begin
        unique case (term_reg)
            pidc_pkg::TERM_P: begin
                cur_value = e0_reg;
                cur_gain  = kp_reg;
            end
            pidc_pkg::TERM_I: begin
                cur_value = window_reg;
                cur_gain  = ki_reg;
            end
            pidc_pkg::TERM_D: begin
                cur_value = diff_reg;
                cur_gain  = kd_reg;
            end
            default: begin
                cur_value = '0;
                cur_gain  = '0;
            end
        endcase
    end

    assign value_abs = cur_value[15] ? (17'd0 - {1'b1, cur_value}) : {1'b0, cur_value};
    assign gain_abs  = cur_gain[15]  ? (17'd0 - {1'b1, cur_gain})  : {1'b0, cur_gain};

    // Correction step of the divide: the reciprocal quotient is at most one short.
    assign rem     = {1'b0, mag_reg} - mul_p[31:0];
    assign q_fixed = (rem >= 32'(pidc_pkg::DIV_SCALE)) ? q_reg + 1'b1 : q_reg;
    assign term_raw = neg_reg ? (16'sd0 - $signed(q_fixed[15:0])) : $signed(q_fixed[15:0]);
    assign cap_s    = $signed({9'd0, cap_reg});

    always_comb begin
        term_val = term_raw;
        if (term_reg == pidc_pkg::TERM_I && cap_reg != 7'd0) begin
            priority if (term_raw > cap_s) begin
                term_val = cap_s;
            end else if (term_raw < -cap_s) begin
                term_val = -cap_s;
            end else begin
                term_val = term_raw;
            end
        end
    end

    // Drive voltage; -120 * correction is exact, so only saturation is needed.
    assign drive_prod = 24'(acc_reg) * pidc_pkg::DRIVE_STEP;
    always_comb begin
        priority if (acc_reg > pidc_pkg::CORR_SAT) begin
            drive_val = -pidc_pkg::DRIVE_LIMIT;
        end else if (acc_reg < -pidc_pkg::CORR_SAT) begin
            drive_val = pidc_pkg::DRIVE_LIMIT;
        end else begin
            drive_val = 15'(24'sd0 - drive_prod);
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pidc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pidc_pkg::ST_MUL_GAIN;
                end
            end
            pidc_pkg::ST_MUL_GAIN:  state_next = pidc_pkg::ST_MUL_RECIP;
            pidc_pkg::ST_MUL_RECIP: state_next = pidc_pkg::ST_MUL_HUND;
            pidc_pkg::ST_MUL_HUND:  state_next = pidc_pkg::ST_FIX;
            pidc_pkg::ST_FIX: begin
                if (term_reg == pidc_pkg::TERM_D) begin
                    state_next = pidc_pkg::ST_DONE;
                end else begin
                    state_next = pidc_pkg::ST_MUL_GAIN;
                end
            end
            pidc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pidc_pkg::ST_IDLE;
                end
            end
            default: state_next = pidc_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier operands.
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            pidc_pkg::ST_IDLE: s_tready = 1'b1;
            pidc_pkg::ST_MUL_GAIN: begin
                mul_a = 32'(value_abs);
                mul_b = 32'(gain_abs);
            end
            pidc_pkg::ST_MUL_RECIP: begin
                mul_a = {1'b0, mul_p[30:0]};
                mul_b = pidc_pkg::RECIP;
            end
            pidc_pkg::ST_MUL_HUND: begin
                mul_a = 32'(mul_p[2*pidc_pkg::MUL_W-1:pidc_pkg::RECIP_SHIFT]);
                mul_b = 32'(pidc_pkg::DIV_SCALE);
            end
            pidc_pkg::ST_FIX, pidc_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state, configuration and error history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pidc_pkg::ST_IDLE;
            term_reg     <= pidc_pkg::TERM_P;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            cap_reg      <= '0;
            e0_reg       <= '0;
            e1_reg       <= '0;
            e2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    pidc_pkg::REG_KP_GAIN:      kp_reg  <= cfg_data;
                    pidc_pkg::REG_KI_GAIN:      ki_reg  <= cfg_data;
                    pidc_pkg::REG_KD_GAIN:      kd_reg  <= cfg_data;
                    pidc_pkg::REG_INTEGRAL_CAP: cap_reg <= cfg_data[6:0];
                    default: begin
                    end
                endcase
            end

            if (s_accept) begin
                e2_reg   <= e1_reg;
                e1_reg   <= e0_reg;
                e0_reg   <= err_in;
                term_reg <= pidc_pkg::TERM_P;
            end else if (state_reg == pidc_pkg::ST_FIX) begin
                unique case (term_reg)
                    pidc_pkg::TERM_P: term_reg <= pidc_pkg::TERM_I;
                    pidc_pkg::TERM_I: term_reg <= pidc_pkg::TERM_D;
                    default:          term_reg <= pidc_pkg::TERM_P;
                endcase
            end

            if (state_reg == pidc_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            window_reg <= e0_reg + e1_reg + e2_reg;
            diff_reg   <= err_in - e0_reg;
            acc_reg    <= '0;
        end
        if (state_reg == pidc_pkg::ST_MUL_GAIN) begin
            neg_reg <= cur_value[15] ^ cur_gain[15];
        end
        if (state_reg == pidc_pkg::ST_MUL_RECIP) begin
            mag_reg <= mul_p[30:0];
        end
        if (state_reg == pidc_pkg::ST_MUL_HUND) begin
            q_reg <= mul_p[2*pidc_pkg::MUL_W-1:pidc_pkg::RECIP_SHIFT];
        end
        if (state_reg == pidc_pkg::ST_FIX) begin
            acc_reg <= acc_reg + term_val;
        end
        if (state_reg == pidc_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= {1'b0, drive_val, acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/pidc_mul.sv =====
module pidc_mul (
    input  logic                          aclk,
    input  logic [pidc_pkg::MUL_W-1:0]    a,
    input  logic [pidc_pkg::MUL_W-1:0]    b,
    output logic [2*pidc_pkg::MUL_W-1:0]  p_reg
);

    // Unsigned multiplier with a registered product; signs are handled outside.
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

// ===== sv/pidc_checker.sv =====
module pidc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A held result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The block is busy in the cycle after it takes a tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an accepted tick");

    // Drive stays within the rail limits and the pad bit is clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31] && $signed(m_tdata[30:16]) <= 15'sd12000
                     && $signed(m_tdata[30:16]) >= -15'sd12000)
        else $error("drive out of range");

    // In the linear range the drive is -120 times the correction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $signed(m_tdata[15:0]) <= 16'sd100 && $signed(m_tdata[15:0]) >= -16'sd100
        |-> $signed(m_tdata[30:16]) == 15'($signed(m_tdata[15:0]) * -16'sd120))
        else $error("drive does not follow correction");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
